/* sv/pid_bilinear_filtered_derivative_defines.svh */
// Assertion macros used by the checker file.
`ifndef PID_BILINEAR_FILTERED_DERIVATIVE_DEFINES_SVH
`define PID_BILINEAR_FILTERED_DERIVATIVE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PBFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PBFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/pbfd_pkg.sv */
// Package: widths, constants and shared helpers of the PID controller.
package pbfd_pkg;

    localparam int DW      = 32;   // sample width
    localparam int FRAC    = 16;
    localparam int ADDR_W  = 5;
    localparam int DEN_W   = 35;   // 4.0 + 2*gT in Q.16
    localparam int DIV_W   = 80;   // |num| << 16 plus rounding term
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam logic signed [63:0] LIM = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic [DEN_W-1:0] Q16_FOUR = DEN_W'(4 << FRAC);

    typedef struct packed {
        logic start;
        logic sh32;     // shift by 32 instead of 16
    } t_mul_ctl;

    function automatic logic [63:0] mag64(input logic signed [63:0] a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

    // add clamped symmetrically at +-(2^63-1)
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(LIM))
            return LIM;
        else if (s < -65'(LIM))
            return -LIM;
        else
            return s[63:0];
    endfunction

endpackage

/* sv/pbfd_if.sv */
// Valid/ready channel interfaces for sample input and drive output.
interface pbfd_in_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic signed [pbfd_pkg::DW-1:0] sample_in;
    modport source (output valid, func, sample_in, input ready);
    modport sink   (input valid, func, sample_in, output ready);
endinterface

interface pbfd_out_if;
    logic                          valid;
    logic                          ready;
    logic signed [pbfd_pkg::DW-1:0] drive_out;
    logic                          saturated;
    modport source (output valid, drive_out, saturated, input ready);
    modport sink   (input valid, drive_out, saturated, output ready);
endinterface

/* sv/pbfd_mul.sv */
// Shared multiplier: 64x64 magnitude product over four 32x32 partial products,
// then round half away from zero, shift by 16 or 32 and saturate.
module pbfd_mul (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  pbfd_pkg::t_mul_ctl       i_ctl,
    input  logic signed [63:0]       i_a,
    input  logic signed [63:0]       i_b,
    output logic                     o_done,
    output logic signed [63:0]       o_p
);

    logic [63:0]        r_ma, r_mb;
    logic               r_neg, r_sh32;
    logic [2:0]         r_cnt;
    logic               r_busy, r_done;
    logic [63:0]        r_pp;
    logic [1:0]         r_psh;
    logic [127:0]       r_acc;
    logic signed [63:0] r_p;

    logic [31:0]        w_opa, w_opb;
    logic [63:0]        w_pp;
    logic [127:0]       w_add;
    logic [64:0]        w_half, w_s;
    logic [63:0]        w_r, w_rc;
    logic signed [63:0] w_fin;

    assign w_opa = r_cnt[0] ? r_ma[63:32] : r_ma[31:0];
    assign w_opb = r_cnt[1] ? r_mb[63:32] : r_mb[31:0];
    assign w_pp  = 64'(w_opa) * 64'(w_opb);

    always_comb begin
        case (r_psh)
            2'd0:    w_add = 128'(r_pp);
            2'd1:    w_add = 128'(r_pp) << 32;
            default: w_add = 128'(r_pp) << 64;
        endcase
    end

    always_comb begin
        w_half = r_sh32 ? 65'h0_8000_0000 : 65'h0_0000_8000;
        w_s    = {1'b0, r_acc[63:0]} + w_half;
        if ((|r_acc[127:64]) || w_s[64])
            w_r = '1;
        else if (r_sh32)
            w_r = {32'b0, w_s[63:32]};
        else
            w_r = {16'b0, w_s[63:16]};
        w_rc  = w_r[63] ? 64'(pbfd_pkg::LIM) : w_r;
        w_fin = r_neg ? -$signed(w_rc) : $signed(w_rc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_ma   <= pbfd_pkg::mag64(i_a);
                r_mb   <= pbfd_pkg::mag64(i_b);
                r_neg  <= i_a[63] ^ i_b[63];
                r_sh32 <= i_ctl.sh32;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt <= 3'd3) begin
                    r_pp  <= w_pp;
                    r_psh <= 2'(r_cnt[0]) + 2'(r_cnt[1]);
                end
                if (r_cnt >= 3'd1 && r_cnt <= 3'd4)
                    r_acc <= r_acc + w_add;
                if (r_cnt == 3'd5) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_p    <= w_fin;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

/* sv/pbfd_div.sv */
// Restoring divider, one quotient bit a cycle: round(|num| * 2^16 / den),
// then sign and clip to the sample range.
module pbfd_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [63:0]                  i_num,
    input  logic [pbfd_pkg::DEN_W-1:0]          i_den,
    output logic                                o_done,
    output logic signed [pbfd_pkg::DW-1:0]      o_drive,
    output logic                                o_sat
);

    localparam int DW    = pbfd_pkg::DW;
    localparam int DEN_W = pbfd_pkg::DEN_W;
    localparam int DIV_W = pbfd_pkg::DIV_W;
    localparam logic [DIV_W-1:0] POS_MAX = DIV_W'((64'd1 << (DW - 1)) - 64'd1);
    localparam logic [DIV_W-1:0] NEG_MAX = DIV_W'(64'd1 << (DW - 1));

    logic [DIV_W-1:0]              r_n;
    logic [DEN_W-1:0]              r_d, r_rem;
    logic [pbfd_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy, r_fin, r_done, r_neg;
    logic signed [DW-1:0]          r_drive;
    logic                          r_sat;

    logic [DEN_W:0]                w_t;
    logic                          w_ge;
    logic [DEN_W:0]                w_diff;
    logic [DIV_W-1:0]              w_n0;
    logic signed [DW-1:0]          w_drive;
    logic                          w_sat;

    assign w_n0   = (DIV_W'(pbfd_pkg::mag64(i_num)) << pbfd_pkg::FRAC)
                  + DIV_W'(i_den >> 1);
    assign w_t    = {r_rem, r_n[DIV_W-1]};
    assign w_ge   = w_t >= {1'b0, r_d};
    assign w_diff = w_t - {1'b0, r_d};

    always_comb begin
        w_sat   = 1'b0;
        w_drive = DW'(-r_n[DW:0]);
        if (!r_neg) begin
            w_drive = r_n[DW-1:0];
            if (r_n > POS_MAX) begin
                w_drive = POS_MAX[DW-1:0];
                w_sat   = 1'b1;
            end
        end else if (r_n > NEG_MAX) begin
            w_drive = NEG_MAX[DW-1:0];
            w_sat   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= pbfd_pkg::DIV_CNT_W'(DIV_W);
                r_n    <= w_n0;
                r_d    <= i_den;
                r_rem  <= '0;
                r_neg  <= i_num[63];
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_t[DEN_W-1:0];
                r_n   <= {r_n[DIV_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == pbfd_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin   <= 1'b0;
                r_done  <= 1'b1;
                r_drive <= w_drive;
                r_sat   <= w_sat;
            end
        end
    end

    assign o_done  = r_done;
    assign o_drive = r_drive;
    assign o_sat   = r_sat;

endmodule

/* sv/pid_bilinear_filtered_derivative.sv */
// PID controller with Tustin-discretized filtered derivative, top level.
// One process item runs ten products one after another through a single 64x64
// multiplier built from four 32x32 partial products, followed by an 80-step
// restoring divide by 4+2gT at one bit per cycle. A clear item zeroes the delay
// line and yields no result. The next item may be taken while a result still
// waits in the output register. Gains, bandwidth and period are written over
// APB at byte offsets 0x00..0x10 and should only change while idle.
module pid_bilinear_filtered_derivative (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pbfd_in_if.sink                        i_in,
    pbfd_out_if.source                     o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pbfd_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int DW = pbfd_pkg::DW;

    typedef enum logic [2:0] {
        REG_KP = 3'd0, REG_KI = 3'd1, REG_KD = 3'd2, REG_G = 3'd3, REG_T = 3'd4
    } t_reg;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MSTART = 7'b0000010,
        ST_MWAIT  = 7'b0000100,
        ST_ACC    = 7'b0001000,
        ST_DSTART = 7'b0010000,
        ST_DWAIT  = 7'b0100000,
        ST_DONE   = 7'b1000000
    } t_state;

    typedef enum logic [3:0] {
        S_GT, S_KPG, S_A, S_BI, S_B, S_KDG, S_T1, S_T2, S_T3, S_T4
    } t_step;

    t_state r_state;
    t_step  r_step;

    logic signed [31:0]    r_kp, r_ki, r_kd;
    logic [31:0]           r_g, r_t;
    logic signed [DW-1:0]  r_u1, r_u2, r_y1, r_y2, r_u;
    logic [31:0]           r_gt;
    logic signed [63:0]    r_tmp, r_a, r_b, r_c, r_num;
    logic                  r_ovalid, r_osat, r_rsat;
    logic signed [DW-1:0]  r_odrive, r_rdrive;

    pbfd_pkg::t_mul_ctl    w_mctl;
    logic signed [63:0]    w_ma, w_mb, w_p;
    logic                  w_mdone, w_ddone, w_dsat;
    logic signed [DW-1:0]  w_ddrive;
    logic [pbfd_pkg::DEN_W-1:0] w_den;
    logic signed [63:0]    w_n2, w_u, w_u1, w_u2, w_c0, w_c1;
    logic                  w_wr;
    t_reg                  w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg'(paddr[4:2]);

    always_comb begin
        unique case (w_idx)
            REG_KP:  prdata = r_kp;
            REG_KI:  prdata = r_ki;
            REG_KD:  prdata = r_kd;
            REG_G:   prdata = r_g;
            REG_T:   prdata = r_t;
            default: prdata = '0;
        endcase
    end

    assign w_u   = 64'(r_u);
    assign w_u1  = 64'(r_u1);
    assign w_u2  = 64'(r_u2);
    assign w_den = pbfd_pkg::Q16_FOUR + {2'b0, r_gt, 1'b0};
    assign w_n2  = 64'(signed'({29'b0, pbfd_pkg::Q16_FOUR}))
                 - $signed({31'b0, r_gt, 1'b0});
    assign w_c0  = pbfd_pkg::sat_add(w_p, 64'(r_kp));
    assign w_c1  = pbfd_pkg::sat_add(w_c0, w_c0);

    // operand select for the shared multiplier
    always_comb begin
        w_mctl.start = (r_state == ST_MSTART);
        w_mctl.sh32  = 1'b0;
        w_ma = '0;
        w_mb = '0;
        case (r_step)
            S_GT:  begin w_ma = 64'(r_g); w_mb = 64'(r_t); w_mctl.sh32 = 1'b1; end
            S_KPG: begin w_ma = 64'(r_kp); w_mb = 64'(r_g); end
            S_A: begin
                w_ma = pbfd_pkg::sat_add(64'(r_ki), r_tmp);
                w_mb = 64'(r_t);
                w_mctl.sh32 = 1'b1;
            end
            S_BI:  begin w_ma = 64'(r_ki); w_mb = 64'(r_gt); end
            S_B:   begin w_ma = r_tmp; w_mb = 64'(r_t); w_mctl.sh32 = 1'b1; end
            S_KDG: begin w_ma = 64'(r_kd); w_mb = 64'(r_g); end
            S_T1:  begin w_ma = r_a; w_mb = w_u - w_u2; end
            S_T2:  begin w_ma = r_b; w_mb = w_u + (w_u1 <<< 1) + w_u2; end
            S_T3:  begin w_ma = r_c; w_mb = w_u - (w_u1 <<< 1) + w_u2; end
            S_T4:  begin w_ma = w_n2; w_mb = 64'(r_y2); end
            default: ;
        endcase
    end

    pbfd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mctl),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mdone),
        .o_p     (w_p)
    );

    pbfd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_DSTART),
        .i_num   (r_num),
        .i_den   (w_den),
        .o_done  (w_ddone),
        .o_drive (w_ddrive),
        .o_sat   (w_dsat)
    );

    assign i_in.ready      = (r_state == ST_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.drive_out = r_odrive;
    assign o_out.saturated = r_osat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= '0; r_ki <= '0; r_kd <= '0; r_g <= '0; r_t <= '0;
            r_u1 <= '0; r_u2 <= '0; r_y1 <= '0; r_y2 <= '0;
            r_state  <= ST_IDLE;
            r_step   <= S_GT;
            r_ovalid <= 1'b0;
        end else begin
            if (w_wr) begin
                case (w_idx)
                    REG_KP:  r_kp <= pwdata;
                    REG_KI:  r_ki <= pwdata;
                    REG_KD:  r_kd <= pwdata;
                    REG_G:   r_g  <= pwdata;
                    REG_T:   r_t  <= pwdata;
                    default: ;
                endcase
            end
            // in ST_DONE the output register is reloaded instead
            if (r_ovalid && o_out.ready && r_state != ST_DONE)
                r_ovalid <= 1'b0;

            unique case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        if (i_in.func) begin
                            r_u1 <= '0; r_u2 <= '0; r_y1 <= '0; r_y2 <= '0;
                        end else begin
                            r_u     <= i_in.sample_in;
                            r_step  <= S_GT;
                            r_state <= ST_MSTART;
                        end
                    end
                end
                ST_MSTART: r_state <= ST_MWAIT;
                ST_MWAIT: begin
                    if (w_mdone) begin
                        case (r_step)
                            S_GT:  r_gt  <= w_p[31:0];
                            S_KPG: r_tmp <= w_p;
                            S_A:   r_a   <= pbfd_pkg::sat_add(w_p, w_p);
                            S_BI:  r_tmp <= w_p;
                            S_B:   r_b   <= w_p;
                            S_KDG: r_c   <= pbfd_pkg::sat_add(w_c1, w_c1);
                            S_T1:  r_num <= w_p;
                            S_T4:  r_num <= pbfd_pkg::sat_add(r_num, -w_p);
                            default: r_num <= pbfd_pkg::sat_add(r_num, w_p);
                        endcase
                        if (r_step == S_T4) begin
                            r_state <= ST_ACC;
                        end else begin
                            r_step  <= t_step'(r_step + 4'd1);
                            r_state <= ST_MSTART;
                        end
                    end
                end
                ST_ACC: begin
                    r_num   <= pbfd_pkg::sat_add(r_num, 64'(r_y1) <<< 3);
                    r_state <= ST_DSTART;
                end
                ST_DSTART: r_state <= ST_DWAIT;
                ST_DWAIT: begin
                    if (w_ddone) begin
                        r_rdrive <= w_ddrive;
                        r_rsat   <= w_dsat;
                        r_state  <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // wait for the output register to free up
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_odrive <= r_rdrive;
                        r_osat   <= r_rsat;
                        r_u2     <= r_u1;
                        r_u1     <= r_u;
                        r_y2     <= r_y1;
                        r_y1     <= r_rdrive;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

/* sv/pbfd_checker.sv */
// Port-level checker for the PID controller, bound to the top level.
`include "pid_bilinear_filtered_derivative_defines.svh"

module pbfd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_in_func,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic signed [pbfd_pkg::DW-1:0] i_drive_out,
    input logic                          i_saturated
);

    localparam logic signed [pbfd_pkg::DW-1:0] MAXV = {1'b0, {(pbfd_pkg::DW-1){1'b1}}};
    localparam logic signed [pbfd_pkg::DW-1:0] MINV = {1'b1, {(pbfd_pkg::DW-1){1'b0}}};

    `PBFD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped before transfer")
    `PBFD_ASSERT_NEXT(a_busy_after_sample, i_clk, i_rst_n, i_in_valid && i_in_ready && !i_in_func, !i_in_ready, "ready while computing")
    `PBFD_ASSERT_NEXT(a_clear_no_result, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_func && !i_out_valid, !i_out_valid, "clear produced a result")
    `PBFD_ASSERT_NOW(a_sat_at_rail, i_clk, i_rst_n, i_out_valid && i_saturated, i_drive_out == MAXV || i_drive_out == MINV, "saturated output not at rail")

endmodule

bind pid_bilinear_filtered_derivative pbfd_checker u_pbfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_func   (i_in.func),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_drive_out (o_out.drive_out),
    .i_saturated (o_out.saturated)
);
